[src/tes_pkg.sv]
// Package for the timed event scheduler: result kinds and shared types.
// No dependencies.
package tes_pkg;

  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_REJECT  = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_RUNNING = 3'd3;
  localparam logic [2:0] KIND_ENDED   = 3'd4;
  localparam logic [2:0] KIND_IDLE    = 3'd5;

  localparam logic REQ_SCHEDULE = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  // control between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

endpackage

[src/tes_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/tes_div.sv]
// Bit-serial restoring divider: min(65536, floor(num*65536/den)), num < den.
// Depends on tes_pkg.
module tes_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tes_pkg::div_req_t req_i,
  output tes_pkg::div_rsp_t rsp_o
);
  import tes_pkg::*;

  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [33:0] trial;

  // one quotient bit per cycle, 16 steps (num < den keeps quotient below 2^16)
  assign trial = {rem_q, 1'b0} - {2'b0, den_q};
  assign rem_d = trial[33] ? {rem_q[31:0], 1'b0} : trial[32:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num};
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[15:0], ~trial[33]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
endmodule

[src/timed_event_scheduler.sv]
// Top level of the timed event scheduler: slot pool, queues, sequencer.
// Depends on tes_pkg, tes_ram, tes_div.
//
// channel | dir | word
// s_axis  | in  | tdata {want_progress,tag,duration,delay,now}, tuser req_type
// m_axis  | out | tdata {progress_valid,progress,event_tag,slot,kind}, tlast
//
// A schedule word walks back through the pending entries that it shifts.
// A tick waits on the bit-serial divider for each active entry that wants progress
// and has not yet ended.
// Each result waits in the output register until taken; the sequencer holds.
// Reset clears busy/running flags and counts; slot tables stay undefined.
module timed_event_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] now_ms, [63:32] delay_ms, [95:64] duration_ms, [111:96] tag,
  // [112] want_progress, [119:113] zero
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] event_kind, [6:3] slot, [22:7] event_tag, [39:23] progress,
  // [40] progress_valid, [47:41] zero
  output logic [47:0]  m_axis_tdata,
  output logic         m_axis_tlast
);
  import tes_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = 81; // due, length, id, reports

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCH   = 4'd1;
  localparam logic [3:0] ST_INS   = 4'd2;
  localparam logic [3:0] ST_INSW  = 4'd3;
  localparam logic [3:0] ST_TPEND = 4'd4;
  localparam logic [3:0] ST_TSTW  = 4'd5;
  localparam logic [3:0] ST_WALK  = 4'd6;
  localparam logic [3:0] ST_WRD   = 4'd7;
  localparam logic [3:0] ST_WDIV  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;
  localparam logic [3:0] ST_SHIFT = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;
  localparam logic [3:0] ST_SHP   = 4'd12;

  logic [3:0]     st_q;
  logic [SLOTS-1:0] busy_q, running_q;
  logic [CW-1:0]  pcnt_q, rcnt_q;
  logic [CW-1:0]  idx_q;
  logic [SW-1:0]  cur_q;
  logic [31:0]    now_q, due_q, len_q;
  logic [15:0]    tag_q;
  logic           wantin_q;
  logic           any_q;

  // small order lists kept as registers, each entry a fixed tap
  logic [SW-1:0]  pord_q [SLOTS];
  logic [SW-1:0]  rord_q [SLOTS];

  // slot table memory: {reports, id, length, due}
  logic           tw_we;
  logic [SW-1:0]  tw_addr, tr_addr;
  logic [80:0]    tw_data, tr_data;
  logic           sw_we;
  logic [31:0]    sr_data;

  tes_ram #(.WIDTH(EW), .DEPTH(1 << SW)) u_tab (
    .clk_i, .we_i(tw_we), .waddr_i(tw_addr), .wdata_i(tw_data),
    .raddr_i(tr_addr), .rdata_o(tr_data)
  );
  tes_ram #(.WIDTH(32), .DEPTH(1 << SW)) u_start (
    .clk_i, .we_i(sw_we), .waddr_i(cur_q), .wdata_i(now_q),
    .raddr_i(tr_addr), .rdata_o(sr_data)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  tes_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // free slot search and output register
  logic [SW-1:0] free_s;
  logic          free_ok;
  always_comb begin
    free_s  = '0;
    free_ok = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_s  = SW'(i);
        free_ok = 1'b1;
      end
    end
  end

  logic [47:0] res_q;
  logic        rlast_q, ovld_q;
  logic [31:0] elapsed;
  logic        ended;
  assign elapsed = now_q - sr_data;
  assign ended   = elapsed >= tr_data[63:32];

  assign s_axis_tready = (st_q == ST_IDLE) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = rlast_q;

  logic [SW-1:0] pidx;
  assign pidx = idx_q[SW-1:0];

  always_comb begin
    tw_we   = 1'b0;
    tw_addr = cur_q;
    tw_data = {wantin_q, tag_q, len_q, due_q};
    sw_we   = (st_q == ST_TSTW);
    tr_addr = cur_q;
    dreq.start = 1'b0;
    dreq.num   = elapsed;
    dreq.den   = tr_data[63:32];
    if (st_q == ST_SCH) tw_we = 1'b1;
    if (st_q == ST_INS) tr_addr = pord_q[pidx - SW'(1)];
    if (st_q == ST_WALK) tr_addr = rord_q[pidx];
    if (st_q == ST_WRD && tr_data[80] && !ended) dreq.start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      busy_q    <= '0;
      running_q <= '0;
      pcnt_q    <= '0;
      rcnt_q    <= '0;
      ovld_q    <= 1'b0;
    end else begin
      if (ovld_q && m_axis_tready) ovld_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            now_q    <= s_axis_tdata[31:0];
            due_q    <= s_axis_tdata[31:0] + s_axis_tdata[63:32];
            len_q    <= s_axis_tdata[95:64];
            tag_q    <= s_axis_tdata[111:96];
            wantin_q <= s_axis_tdata[112];
            any_q    <= 1'b0;
            idx_q    <= pcnt_q;
            if (s_axis_tuser == REQ_SCHEDULE) begin
              if (!free_ok || pcnt_q >= CW'(SLOTS)) begin
                res_q   <= {8'b0, 17'b0, s_axis_tdata[111:96], 4'b0, KIND_REJECT};
                rlast_q <= 1'b1;
                ovld_q  <= 1'b1;
              end else begin
                cur_q <= free_s;
                st_q  <= ST_SCH;
              end
            end else begin
              st_q <= ST_TPEND;
            end
          end
        end
        ST_SCH: begin
          busy_q[cur_q]    <= 1'b1;
          running_q[cur_q] <= 1'b0;
          st_q <= ST_INS;
        end
        ST_INS: begin
          if (idx_q == '0) st_q <= ST_SHP;
          else st_q <= ST_INSW;
        end
        ST_INSW: begin
          // tr_data holds due of pord[idx-1]
          if (tr_data[31:0] > due_q) begin
            pord_q[pidx] <= pord_q[pidx - SW'(1)];
            idx_q <= idx_q - CW'(1);
            st_q  <= ST_INS;
          end else begin
            st_q <= ST_SHP;
          end
        end
        ST_SHP: begin
          if (!ovld_q) begin
            pord_q[pidx] <= cur_q;
            pcnt_q <= pcnt_q + CW'(1);
            res_q  <= {8'b0, 17'b0, tag_q, 4'(cur_q), KIND_ACCEPT};
            rlast_q <= 1'b1;
            ovld_q <= 1'b1;
            st_q   <= ST_IDLE;
          end
        end
        ST_TPEND: begin
          cur_q <= pord_q[0];
          st_q  <= (pcnt_q != '0 && rcnt_q < CW'(SLOTS)) ? ST_TSTW : ST_WALK;
          idx_q <= '0;
        end
        ST_TSTW: begin
          // start memory written this cycle whether or not due; rewrite is harmless
          // because a queued slot is never read for start time
          st_q <= ST_OUT;
        end
        ST_OUT: begin
          // reads table of head to check due
          if (!ovld_q) begin
            if (tr_data[31:0] <= now_q && idx_q == '0 && !any_q) begin
              for (int i = 0; i < SLOTS - 1; i++) pord_q[i] <= pord_q[i + 1];
              pcnt_q <= pcnt_q - CW'(1);
              running_q[cur_q] <= 1'b1;
              rord_q[rcnt_q[SW-1:0]] <= cur_q;
              rcnt_q <= rcnt_q + CW'(1);
              res_q  <= {8'b0, 17'b0, tr_data[79:64], 4'(cur_q), KIND_START};
              any_q  <= 1'b1;
              ovld_q <= 1'b0;
              // held locally; ST_FIN shows it with tlast low
              st_q   <= ST_FIN;
            end else begin
              st_q <= ST_WALK;
            end
          end
        end
        ST_FIN: begin
          // started entry is on the active list, so the walk always follows
          ovld_q  <= 1'b1;
          rlast_q <= 1'b0;
          st_q    <= ST_WALK;
          any_q   <= 1'b1;
        end
        ST_WALK: begin
          if (!ovld_q) begin
            if (idx_q >= rcnt_q) begin
              if (!any_q) begin
                res_q   <= {45'b0, KIND_IDLE};
                rlast_q <= 1'b1;
                ovld_q  <= 1'b1;
              end
              st_q <= ST_IDLE;
            end else begin
              cur_q <= rord_q[pidx];
              st_q  <= ST_WRD;
            end
          end
        end
        ST_WRD: begin
          st_q <= (tr_data[80] && !ended) ? ST_WDIV : ST_SHIFT;
        end
        ST_WDIV: begin
          if (drsp.done) st_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!ovld_q) begin
            res_q <= {7'b0, tr_data[80],
                      (!tr_data[80]) ? 17'd0 : (ended ? 17'h10000 : drsp.quot),
                      tr_data[79:64], 4'(cur_q), ended ? KIND_ENDED : KIND_RUNNING};
            rlast_q <= (idx_q + CW'(1) >= rcnt_q) ? 1'b1 : 1'b0;
            ovld_q  <= 1'b1;
            any_q   <= 1'b1;
            if (ended) begin
              busy_q[cur_q]    <= 1'b0;
              running_q[cur_q] <= 1'b0;
              for (int i = 0; i < SLOTS - 1; i++) begin
                if (CW'(i) >= idx_q) rord_q[i] <= rord_q[i + 1];
              end
              rcnt_q <= rcnt_q - CW'(1);
            end else begin
              idx_q <= idx_q + CW'(1);
            end
            st_q <= ST_WALK;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= CW'(SLOTS)) else $error("running count overflow");
  a_pcnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= CW'(SLOTS)) else $error("pending count overflow");
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_q & ~busy_q) == '0) else $error("running slot not busy");
`endif
endmodule

[test/timed_event_scheduler_tb.sv]
// Self-checking bench for timed_event_scheduler: random and directed schedule/tick words.
// Depends on tes_pkg and the scheduler RTL; the predictor below tracks the slot pool.
`timescale 1ns / 1ps

module timed_event_scheduler_tb;
  import tes_pkg::*;

  localparam int NSLOT       = 16;
  localparam int N_RANDOM    = 360;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 800;

  typedef struct {
    logic        req;
    logic [31:0] now;
    logic [31:0] delay;
    logic [31:0] dur;
    logic [15:0] tag;
    logic        wp;
    int          phase;
  } word_t;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] tag;
    logic [16:0] prog;
    logic        pv;
    logic        last;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tlast;

  timed_event_scheduler #(.SLOTS(NSLOT)) dut (.*);

  always #4 clk_i = ~clk_i;

  // idle percentages per phase: none, sender, receiver, both
  int send_idle_pct [4] = '{0, 88, 0, 21};
  int recv_stall_pct[4] = '{0, 0, 88, 21};
  int cur_phase = 0;

  word_t   word_q[$];      // words waiting to be driven
  result_t expected_q[$];  // results predicted, not yet seen
  word_t   cur_word;
  int      errors = 0;
  int      cycles = 0;

  // shadow of the pool
  bit          p_busy [NSLOT];
  logic [31:0] p_due  [NSLOT];
  logic [31:0] p_len  [NSLOT];
  logic [31:0] p_start[NSLOT];
  logic [15:0] p_id   [NSLOT];
  bit          p_rep  [NSLOT];
  int          pending_q[$];
  int          active_q[$];

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic logic [16:0] ratio_q16(input logic [31:0] el, input logic [31:0] len);
    logic [63:0] q;
    if (len == 0 || el >= len) return 17'd65536;
    q = {16'd0, el, 16'd0} / {32'd0, len};
    return q[16:0];
  endfunction

  // Advance the shadow pool by one accepted word and queue its results.
  task automatic predict_word(input word_t w);
    result_t     res[$];
    result_t     r;
    int          s, pos, i;
    logic [31:0] due, el;
    bit          want;
    if (w.req == REQ_SCHEDULE) begin
      due = w.now + w.delay;
      s = -1;
      for (i = 0; i < NSLOT; i++)
        if (s < 0 && !p_busy[i]) s = i;
      if (s < 0 || pending_q.size() >= NSLOT) begin
        r = '{KIND_REJECT, 4'd0, w.tag, 17'd0, 1'b0, 1'b0};
      end else begin
        p_busy[s] = 1; p_due[s] = due; p_len[s] = w.dur;
        p_id[s] = w.tag; p_rep[s] = w.wp;
        pos = pending_q.size();
        while (pos > 0 && p_due[pending_q[pos-1]] > due) pos--;
        pending_q.insert(pos, s);
        r = '{KIND_ACCEPT, s[3:0], w.tag, 17'd0, 1'b0, 1'b0};
      end
      res.push_back(r);
    end else begin
      // start at most the front of the due queue
      if (pending_q.size() > 0 && active_q.size() < NSLOT) begin
        s = pending_q[0];
        if (p_due[s] <= w.now) begin
          void'(pending_q.pop_front());
          p_start[s] = w.now;
          active_q.push_back(s);
          r = '{KIND_START, s[3:0], p_id[s], 17'd0, 1'b0, 1'b0};
          res.push_back(r);
        end
      end
      i = 0;
      while (i < active_q.size()) begin
        s = active_q[i];
        el = w.now - p_start[s];
        want = p_rep[s];
        r.slot = s[3:0]; r.tag = p_id[s]; r.pv = want; r.last = 0;
        r.prog = want ? ratio_q16(el, p_len[s]) : 17'd0;
        if (el >= p_len[s]) begin
          r.kind = KIND_ENDED;
          p_busy[s] = 0;
          active_q.delete(i);
        end else begin
          r.kind = KIND_RUNNING;
          i++;
        end
        res.push_back(r);
      end
      if (res.size() == 0) begin
        r = '{KIND_IDLE, 4'd0, 16'd0, 17'd0, 1'b0, 1'b0};
        res.push_back(r);
      end
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[k]) expected_q.push_back(res[k]);
  endtask

  // driver: one word in flight, next loaded when the slot frees unless the sender idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_word(cur_word);
      if (word_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct[word_q[0].phase]) begin
        cur_word = word_q.pop_front();
        cur_phase = cur_word.phase;
        s_axis_tdata  <= {7'd0, cur_word.wp, cur_word.tag, cur_word.dur,
                          cur_word.delay, cur_word.now};
        s_axis_tuser  <= cur_word.req;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, compare each taken word
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[2:0] !== e.kind)
            report($sformatf("kind %0d, want %0d", m_axis_tdata[2:0], e.kind));
          if (m_axis_tdata[6:3] !== e.slot)
            report($sformatf("slot %0d, want %0d", m_axis_tdata[6:3], e.slot));
          if (m_axis_tdata[22:7] !== e.tag)
            report($sformatf("tag %h, want %h", m_axis_tdata[22:7], e.tag));
          if (m_axis_tdata[39:23] !== e.prog)
            report($sformatf("progress %h, want %h", m_axis_tdata[39:23], e.prog));
          if (m_axis_tdata[40] !== e.pv)
            report($sformatf("progress_valid %b, want %b", m_axis_tdata[40], e.pv));
          if (m_axis_tlast !== e.last)
            report($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed_event_scheduler test failed");
      $finish;
    end
  end

  logic [31:0] t_now;
  int          n_words;

  task automatic add_sched(input logic [31:0] delay, input logic [31:0] dur,
                           input logic [15:0] tag, input logic wp, input int ph);
    word_q.push_back('{REQ_SCHEDULE, t_now, delay, dur, tag, wp, ph});
    n_words++;
  endtask

  task automatic add_tick(input logic [31:0] now, input int ph);
    word_q.push_back('{REQ_TICK, now, $urandom, $urandom, 16'($urandom),
                       1'($urandom), ph});
    n_words++;
  endtask

  initial begin
    int ph, k, n;
    t_now = 0;
    n_words = 0;
    // directed: idle tick, zero duration, tag/field extremes, equal due times
    add_tick(0, 0);
    add_sched(0, 0, 16'hFFFF, 1, 0);
    add_tick(0, 0);
    t_now = 1;
    add_sched(4, 10, 16'h0000, 1, 0);
    add_sched(4, 10, 16'h1234, 0, 0);       // same due, must follow FIFO
    add_tick(5, 0);
    add_tick(6, 0);
    add_tick(9, 0);
    add_tick(15, 0);
    add_tick(16, 0);
    // clock wrap across a running event
    t_now = 32'hFFFFFFF0;
    add_sched(0, 32'h20, 16'hA5A5, 1, 0);
    add_tick(32'hFFFFFFF0, 0);
    add_tick(32'h00000008, 0);
    add_tick(32'h00000010, 0);
    add_tick(32'h00000011, 0);
    t_now = 32'h40;
    // random: mostly well-formed sequences, some bursts and noise
    while (n_words < N_RANDOM + 15) begin
      ph = ((n_words - 15) * 4) / N_RANDOM;
      if (ph > 3) ph = 3;
      k = $urandom_range(9);
      if (k <= 5) begin
        n = $urandom_range(1, 4);
        repeat (n) add_sched($urandom_range(8), $urandom_range(20), 16'($urandom),
                             1'($urandom), ph);
        repeat ($urandom_range(2, 8)) begin
          t_now = t_now + $urandom_range(6);
          add_tick(t_now, ph);
        end
      end else if (k == 6) begin
        // fill the pool past full, then drain
        repeat (18) add_sched($urandom_range(3), $urandom_range(1, 30), 16'($urandom),
                              1'($urandom), ph);
        repeat (24) begin
          t_now = t_now + $urandom_range(1, 3);
          add_tick(t_now, ph);
        end
      end else if (k == 7) begin
        add_sched($urandom, $urandom, 16'($urandom), 1'($urandom), ph);
        if ($urandom_range(1)) begin
          t_now = $urandom;
          add_tick(t_now, ph);
        end
      end else if (k == 8) begin
        add_sched($urandom_range(100), $urandom_range(1, 5000), 16'($urandom), 1, ph);
        t_now = t_now + $urandom_range(5000);
        add_tick(t_now, ph);
        t_now = t_now + $urandom_range(5000);
        add_tick(t_now, ph);
      end else begin
        // flush: start due entries, at most one per tick, then step the clock back to end those running
        repeat (4) add_tick(32'hFFFFFFFF, ph);
        repeat (3) add_tick(32'hFFFFFFFE, ph);
        t_now = $urandom_range(1000);
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_q.size() > 0)
      report($sformatf("%0d results never arrived", expected_q.size()));
    if (errors == 0) begin
      $display("timed_event_scheduler test passed");
    end else begin
      $display("timed_event_scheduler test failed");
    end
    $finish;
  end

endmodule
